>>> rtl/core/irpde_pkg.sv
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants of the IR pulse-distance encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

    localparam int unsigned DUR_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned ADDR_W = 3;

    // register indexes of the configuration port
    localparam logic [ADDR_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ONE_MARK     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ZERO_MARK    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ZERO_SPACE   = 3'd5;
    localparam logic [ADDR_W-1:0] REG_TRAILER_MARK = 3'd6;

    // reset values of the duration registers
    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4500;
    localparam logic [DUR_W-1:0] RST_ONE_MARK     = 16'd560;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1690;
    localparam logic [DUR_W-1:0] RST_ZERO_MARK    = 16'd560;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;
    localparam logic [DUR_W-1:0] RST_TRAILER_MARK = 16'd560;

    // symbol positions within one item: header, 16 bit symbols, trailer
    localparam logic [IDX_W-1:0] IDX_HEADER_MARK  = 5'd0;
    localparam logic [IDX_W-1:0] IDX_HEADER_SPACE = 5'd1;
    localparam logic [IDX_W-1:0] IDX_FIRST_BIT    = 5'd2;
    localparam logic [IDX_W-1:0] IDX_LAST_BIT     = 5'd17;
    localparam logic [IDX_W-1:0] IDX_TRAILER      = 5'd18;

    typedef struct packed {
        logic [DUR_W-1:0] hdr_burst;
        logic [DUR_W-1:0] hdr_gap;
        logic [DUR_W-1:0] one_burst;
        logic [DUR_W-1:0] one_gap;
        logic [DUR_W-1:0] zero_burst;
        logic [DUR_W-1:0] zero_gap;
        logic [DUR_W-1:0] tail_burst;
    } t_cfg;

    // classified item: byte plus first and last symbol position
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  start_idx;
        logic [IDX_W-1:0]  end_idx;
    } t_job;

    typedef struct packed {
        logic             is_mark;
        logic [DUR_W-1:0] duration;
        logic             end_of_frame;
        logic             end_of_item;
    } t_sym;

endpackage

>>> rtl/core/irpde_front.sv
// ----------------------------------------------------------------------------
// irpde_front
// Accepts frame bytes, classifies them into symbol ranges, queues up to two jobs.
// ----------------------------------------------------------------------------
module irpde_front
    import irpde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    output logic              o_job_valid,
    output t_job              o_job,
    input  logic              i_job_take
);

    t_job       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       wr_en, rd_en;
    t_job       job_in;

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_job_take && o_job_valid;

    always_comb begin
        job_in.data      = i_data_byte;
        job_in.start_idx = i_first_byte ? IDX_HEADER_MARK : IDX_FIRST_BIT;
        job_in.end_idx   = i_last_byte ? IDX_TRAILER : IDX_LAST_BIT;
    end

    always_comb begin
        n_wr_ptr = wr_en ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = rd_en ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_cnt == 2'd0) |=> o_job_valid)
        else $error("accepted beat not visible to back end");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("front queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/irpde_back.sv
// ----------------------------------------------------------------------------
// irpde_back
// Symbol sequencer: walks one job a symbol per cycle, while the result queue has room, into a 2-deep result queue.
// ----------------------------------------------------------------------------
module irpde_back
    import irpde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_take,
    output logic             o_empty,
    input  logic             i_pop,
    output t_sym             o_sym
);

    // sequencer
    logic              r_busy, n_busy;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_end, n_end;
    logic [BYTE_W-1:0] r_byte, n_byte;

    // result queue
    t_sym       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;

    logic room, emit, done, pop_ok;
    t_sym sym;

    assign room       = (r_cnt != 2'd2);
    assign emit       = r_busy && room;
    assign done       = emit && (r_idx == r_end);
    assign o_job_take = i_job_valid && (!r_busy || done);
    assign pop_ok     = i_pop && (r_cnt != 2'd0);
    assign o_empty    = (r_cnt == 2'd0);
    assign o_sym      = r_q[r_rd_ptr];

    always_comb begin
        sym.is_mark      = ~r_idx[0];
        sym.end_of_frame = (r_idx == IDX_TRAILER);
        sym.end_of_item  = (r_idx == r_end);
        if (r_idx == IDX_HEADER_MARK) begin
            sym.duration = i_cfg.hdr_burst;
        end else if (r_idx == IDX_HEADER_SPACE) begin
            sym.duration = i_cfg.hdr_gap;
        end else if (r_idx == IDX_TRAILER) begin
            sym.duration = i_cfg.tail_burst;
        end else if (r_byte[BYTE_W-1]) begin
            sym.duration = r_idx[0] ? i_cfg.one_gap : i_cfg.one_burst;
        end else begin
            sym.duration = r_idx[0] ? i_cfg.zero_gap : i_cfg.zero_burst;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_end  = r_end;
        n_byte = r_byte;
        if (o_job_take) begin
            n_busy = 1'b1;
            n_idx  = i_job.start_idx;
            n_end  = i_job.end_idx;
            n_byte = i_job.data;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_idx = r_idx + 1'b1;
            // advance to the next bit after its space symbol
            if (r_idx[0] && r_idx > IDX_HEADER_SPACE) begin
                n_byte = {r_byte[BYTE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_busy   <= n_busy;
            r_wr_ptr <= emit ? ~r_wr_ptr : r_wr_ptr;
            r_rd_ptr <= pop_ok ? ~r_rd_ptr : r_rd_ptr;
            r_cnt    <= r_cnt + {1'b0, emit} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_end  <= n_end;
        r_byte <= n_byte;
        if (emit) begin
            r_q[r_wr_ptr] <= sym;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_end && r_end >= IDX_LAST_BIT))
        else $error("symbol index past end of job");

    a_trailer_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && sym.end_of_frame) |-> (sym.end_of_item && sym.is_mark))
        else $error("trailer symbol not flagged as end of item");

    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> (!r_busy || done))
        else $error("job taken while sequencer busy");
`endif

endmodule

>>> rtl/core/ir_pulse_distance_encoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_core
// IR pulse-distance transmit encoder: frame bytes in, mark/space symbols out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_push / o_full      i_data_byte, i_first_byte, i_last_byte
//  result    out        o_empty / i_pop      o_is_mark, o_duration_us,
//                                            o_end_of_frame, o_end_of_item
//  config    in         i_cfg_wr_en          i_cfg_addr, i_cfg_wdata
//
//  The sequencer emits one symbol per cycle while the result queue has room: a
//  byte gives 16 symbols, 18 with a header, 17 with a trailer, 19 with both.
//  A 2-deep job queue takes bytes while the sequencer works; a 2-deep result
//  queue decouples the sequencer from pop.
//  Reset (synchronous) empties both queues and loads the default durations.
//  A full result queue holds the sequencer; bytes then collect in the job queue.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder_core
    import irpde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [DUR_W-1:0]  i_cfg_wdata,
    input  logic              i_push,
    output logic              o_full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    output logic              o_empty,
    input  logic              i_pop,
    output logic              o_is_mark,
    output logic [DUR_W-1:0]  o_duration_us,
    output logic              o_end_of_frame,
    output logic              o_end_of_item
);

    t_cfg r_cfg, n_cfg;
    logic job_valid, job_take;
    t_job job;
    t_sym sym;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_HEADER_MARK:  n_cfg.hdr_burst  = i_cfg_wdata;
                REG_HEADER_SPACE: n_cfg.hdr_gap    = i_cfg_wdata;
                REG_ONE_MARK:     n_cfg.one_burst  = i_cfg_wdata;
                REG_ONE_SPACE:    n_cfg.one_gap    = i_cfg_wdata;
                REG_ZERO_MARK:    n_cfg.zero_burst = i_cfg_wdata;
                REG_ZERO_SPACE:   n_cfg.zero_gap   = i_cfg_wdata;
                REG_TRAILER_MARK: n_cfg.tail_burst = i_cfg_wdata;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_burst  <= RST_HEADER_MARK;
            r_cfg.hdr_gap    <= RST_HEADER_SPACE;
            r_cfg.one_burst  <= RST_ONE_MARK;
            r_cfg.one_gap    <= RST_ONE_SPACE;
            r_cfg.zero_burst <= RST_ZERO_MARK;
            r_cfg.zero_gap   <= RST_ZERO_SPACE;
            r_cfg.tail_burst <= RST_TRAILER_MARK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    irpde_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_take   (job_take)
    );

    irpde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_sym       (sym)
    );

    assign o_is_mark      = sym.is_mark;
    assign o_duration_us  = sym.duration;
    assign o_end_of_frame = sym.end_of_frame;
    assign o_end_of_item  = sym.end_of_item;

endmodule

>>> bench/ir_pulse_distance_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_core_tb
// Self-checking bench for the IR pulse-distance encoder core.
// Frame bytes go in through the push/full queue port. Each symbol that comes
// out through the empty/pop port is checked against a symbol list that the
// bench builds itself from the byte, its flags and its own copy of the
// duration registers. Directed tests cover the default durations, frame flag
// sequences and the duration extremes. A random phase then sends frames with
// random content, mixed with stray bytes, under changing durations and with
// random idling on both sides.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder_core_tb;
    import irpde_pkg::*;

    localparam int unsigned     REG_COUNT    = 7;
    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned     MAX_IDLE     = 16;
    localparam int unsigned     MAX_SHOWN    = 10;
    localparam int unsigned     DRAIN_CYCLES = 8;
    localparam int unsigned     RANDOM_ITEMS = 95;
    localparam int unsigned     PHASE_ITEMS  = 25;
    localparam longint unsigned TIMEOUT_NS   = 5_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [DUR_W-1:0]  i_cfg_wdata = '0;
    logic              i_push = 1'b0;
    logic              o_full;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_first_byte = 1'b0;
    logic              i_last_byte = 1'b0;
    logic              o_empty;
    logic              i_pop = 1'b0;
    logic              o_is_mark;
    logic [DUR_W-1:0]  o_duration_us;
    logic              o_end_of_frame;
    logic              o_end_of_item;

    ir_pulse_distance_encoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_is_mark      (o_is_mark),
        .o_duration_us  (o_duration_us),
        .o_end_of_frame (o_end_of_frame),
        .o_end_of_item  (o_end_of_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [DUR_W-1:0] dur_cfg [0:REG_COUNT-1];
    t_sym             pending_symbols [$];
    t_sym             got_sym;
    t_sym             want_sym;
    bit               src_idle = 1'b0;
    bit               pop_idle = 1'b0;
    int               pop_stall = 0;
    int               err_count = 0;
    int               bytes_sent = 0;
    int               symbols_checked = 0;
    int               reg_writes = 0;

    function automatic void push_sym(input logic mark, input logic [DUR_W-1:0] dur,
                                     input logic eof, input logic eoi);
        t_sym s;
        s.is_mark      = mark;
        s.duration     = dur;
        s.end_of_frame = eof;
        s.end_of_item  = eoi;
        pending_symbols.push_back(s);
    endfunction

    // header, then one mark/space pair per bit MSB first, then the trailer
    function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic f,
                                        input logic l);
        int i;
        if (f) begin
            push_sym(1'b1, dur_cfg[REG_HEADER_MARK], 1'b0, 1'b0);
            push_sym(1'b0, dur_cfg[REG_HEADER_SPACE], 1'b0, 1'b0);
        end
        for (i = BYTE_W - 1; i >= 0; i--) begin
            if (b[i]) begin
                push_sym(1'b1, dur_cfg[REG_ONE_MARK], 1'b0, 1'b0);
                push_sym(1'b0, dur_cfg[REG_ONE_SPACE], 1'b0, !l && i == 0);
            end else begin
                push_sym(1'b1, dur_cfg[REG_ZERO_MARK], 1'b0, 1'b0);
                push_sym(1'b0, dur_cfg[REG_ZERO_SPACE], 1'b0, !l && i == 0);
            end
        end
        if (l)
            push_sym(1'b1, dur_cfg[REG_TRAILER_MARK], 1'b1, 1'b1);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l);
        int gap;
        gap = src_idle ? $urandom_range(MAX_IDLE, 0) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push       = 1'b1;
        i_data_byte  = b;
        i_first_byte = f;
        i_last_byte  = l;
        do @(posedge i_clk); while (o_full);
        encode_byte(b, f, l);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DUR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = val;
        @(posedge i_clk);
        if (addr < REG_COUNT)
            dur_cfg[addr] = val;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // drop push, let every expected symbol drain, then settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_push = 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [DUR_W-1:0] val);
        int i;
        for (i = 0; i < REG_COUNT; i++)
            write_reg(ADDR_W'(i), val);
    endtask

    task automatic load_random_durations();
        int i;
        logic [DUR_W-1:0] v;
        for (i = 0; i < REG_COUNT; i++) begin
            case ($urandom_range(3, 0))
                0: v = '0;
                1: v = '1;
                2: v = DUR_W'($urandom);
                default: v = DUR_W'($urandom_range(2000, 1));
            endcase
            write_reg(ADDR_W'(i), v);
        end
        if ($urandom_range(1, 0))
            write_reg(REG_UNUSED, DUR_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        src_idle = 1'b0;
        pop_idle = 1'b0;
        send_byte(8'hA5, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_frame_sequencing();
        src_idle = 1'b1;
        pop_idle = 1'b1;
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        // bare byte after a closed frame, then a header in the middle of a frame
        send_byte(8'h7E, 1'b0, 1'b0);
        send_byte(8'h81, 1'b1, 1'b0);
        send_byte(8'h96, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_duration_extremes();
        src_idle = 1'b0;
        pop_idle = 1'b1;
        write_all_regs('0);
        write_reg(REG_UNUSED, '1);
        send_byte(8'hA5, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b1);
        wait_idle();
        write_all_regs('1);
        write_reg(REG_UNUSED, '0);
        send_byte(8'h0F, 1'b1, 1'b1);
        send_byte(8'hF0, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int target;
        int phase_items;
        int len;
        int k;
        target      = bytes_sent + RANDOM_ITEMS;
        phase_items = PHASE_ITEMS;
        while (bytes_sent < target) begin
            if (phase_items >= PHASE_ITEMS) begin
                wait_idle();
                load_random_durations();
                src_idle    = $urandom_range(3, 0) != 0;
                pop_idle    = $urandom_range(3, 0) != 0;
                phase_items = 0;
            end
            if ($urandom_range(9, 0) < 8) begin
                len = $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                    send_byte(BYTE_W'($urandom), k == 0, k == len - 1);
                phase_items += len;
            end else begin
                // stray byte with arbitrary flags
                send_byte(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                phase_items++;
            end
        end
        wait_idle();
    endtask

    // result side: hold pop low for a drawn number of cycles after each beat
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop = 1'b0;
        end else if (pop_stall > 0) begin
            i_pop = 1'b0;
            pop_stall--;
        end else begin
            i_pop = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            got_sym.is_mark      = o_is_mark;
            got_sym.duration     = o_duration_us;
            got_sym.end_of_frame = o_end_of_frame;
            got_sym.end_of_item  = o_end_of_item;
            if (pending_symbols.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("ERROR: unexpected symbol mark=%0b dur=%0d eof=%0b eoi=%0b",
                             got_sym.is_mark, got_sym.duration,
                             got_sym.end_of_frame, got_sym.end_of_item);
            end else begin
                want_sym = pending_symbols.pop_front();
                symbols_checked++;
                if (got_sym.is_mark !== want_sym.is_mark
                        || got_sym.duration !== want_sym.duration
                        || got_sym.end_of_frame !== want_sym.end_of_frame
                        || got_sym.end_of_item !== want_sym.end_of_item) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display({"ERROR: symbol %0d expected mark=%0b dur=%0d eof=%0b ",
                                  "eoi=%0b, got mark=%0b dur=%0d eof=%0b eoi=%0b"},
                                 symbols_checked, want_sym.is_mark, want_sym.duration,
                                 want_sym.end_of_frame, want_sym.end_of_item,
                                 got_sym.is_mark, got_sym.duration,
                                 got_sym.end_of_frame, got_sym.end_of_item);
                end
            end
            pop_stall = pop_idle ? $urandom_range(MAX_IDLE, 0) : 0;
        end
    end

    initial begin
        dur_cfg[REG_HEADER_MARK]  = RST_HEADER_MARK;
        dur_cfg[REG_HEADER_SPACE] = RST_HEADER_SPACE;
        dur_cfg[REG_ONE_MARK]     = RST_ONE_MARK;
        dur_cfg[REG_ONE_SPACE]    = RST_ONE_SPACE;
        dur_cfg[REG_ZERO_MARK]    = RST_ZERO_MARK;
        dur_cfg[REG_ZERO_SPACE]   = RST_ZERO_SPACE;
        dur_cfg[REG_TRAILER_MARK] = RST_TRAILER_MARK;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_frame_sequencing();
        test_duration_extremes();
        test_random_frames();

        $display("Run covered %0d bytes, %0d symbols checked, %0d register writes.",
                 bytes_sent, symbols_checked, reg_writes);
        $display("Mismatches or unexpected symbols: %0d", err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d symbols still expected", pending_symbols.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/core/irpde_pkg.sv
rtl/core/irpde_front.sv
rtl/core/irpde_back.sv
rtl/core/ir_pulse_distance_encoder_core.sv
bench/ir_pulse_distance_encoder_core_tb.sv
